>>> design/remote_address_table_insert_defines.svh
// Assertion macros for the remote address table insert module.
// Each one samples on clk_i and is disabled while rst_ni is low.
`ifndef REMOTE_ADDRESS_TABLE_INSERT_DEFINES_SVH
`define REMOTE_ADDRESS_TABLE_INSERT_DEFINES_SVH

`ifndef SYNTHESIS
`define RATI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RATI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RATI_ASSERT(lbl, prop, msg)
`define RATI_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> design/rati_pkg.sv
`timescale 1ns / 1ps

package rati_pkg;

  localparam int unsigned MAX_ENTRIES = 8;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned IDENT_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned COUNT_W  = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [PORT_W-1:0]  port;
    logic [IDENT_W-1:0] ident;
  } entry_t;

  typedef struct packed {
    logic   re;
    idx_t   raddr;
    logic   we;
    idx_t   waddr;
    entry_t wdata;
  } mem_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED  = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_APPENDED = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

endpackage

>>> design/remote_address_table_insert.sv
// After acceptance S_START settles a zero identifier or an empty table at once; otherwise
// S_SCAN reads the filled entries, at most MAX_ENTRIES, before S_RESULT loads the outputs.
// Items are taken one at a time: in_ready_o is high only in S_IDLE, so a new item waits for the
// one-read-per-cycle scan and for S_RESULT, which holds until the previous result is taken.
// Reset: asynchronous, active low; clears the fill count and the handshake state.
// Table contents are not cleared: only filled entries are ever read.
`timescale 1ns / 1ps
`include "remote_address_table_insert_defines.svh"

module remote_address_table_insert import rati_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [PORT_W-1:0]   port_i,
  input  logic [IDENT_W-1:0]  addr_ident_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                list_changed_o,
  output logic [INDEX_W-1:0]  entry_index_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RESULT = 4'b1000
  } fsm_e;

  fsm_e     state_q, state_d;
  idx_t     k_q, k_d;
  cnt_t     count_q, count_d;
  entry_t   item_q;
  status_e  res_status_q, res_status_d;
  idx_t     res_idx_q, res_idx_d;
  mem_req_t mem_req;
  entry_t   rdata;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_changed_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic in_accept, can_emit, load_out;
  logic last, hit_match, hit_upd, full;

  rati_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;

  assign last      = ((cnt_t'(k_q) + cnt_t'(1)) == count_q);
  assign hit_match = (rdata.address == item_q.address) && (rdata.port == item_q.port);
  assign hit_upd   = (rdata.ident == item_q.ident) && (rdata.address != item_q.address);
  assign full      = (count_q == cnt_t'(MAX_ENTRIES));

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    load_out     = 1'b0;
    mem_req       = '0;
    mem_req.wdata = item_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (item_q.ident == '0) begin
          res_status_d = ST_IGNORED;
          res_idx_d    = '0;
          state_d      = S_RESULT;
        end else if (count_q == '0) begin
          // Empty table: append straight away.
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          count_d       = cnt_t'(1);
          res_status_d  = ST_APPENDED;
          res_idx_d     = '0;
          state_d       = S_RESULT;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = '0;
          k_d           = '0;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        // Entry k_q is on the read port; entry k_q + 1 is fetched alongside unless the scan ends here.
        if (hit_match) begin
          res_status_d = ST_PRESENT;
          res_idx_d    = k_q;
          state_d      = S_RESULT;
        end else if (hit_upd) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = k_q;
          res_status_d  = ST_UPDATED;
          res_idx_d     = k_q;
          state_d       = S_RESULT;
        end else if (last) begin
          state_d = S_RESULT;
          if (full) begin
            res_status_d = ST_FULL;
            res_idx_d    = '0;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = count_q[IDX_W-1:0];
            count_d       = count_q + cnt_t'(1);
            res_status_d  = ST_APPENDED;
            res_idx_d     = count_q[IDX_W-1:0];
          end
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = k_q + idx_t'(1);
          k_d           = k_q + idx_t'(1);
        end
      end
      S_RESULT: begin
        if (can_emit) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (in_accept) begin
      item_q.address <= address_i;
      item_q.port    <= port_i;
      item_q.ident   <= addr_ident_i;
    end
    if (load_out) begin
      out_status_q  <= res_status_q;
      out_changed_q <= (res_status_q == ST_UPDATED) || (res_status_q == ST_APPENDED);
      out_index_q   <= INDEX_W'(res_idx_q);
      out_count_q   <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign list_changed_o = out_changed_q;
  assign entry_index_o  = out_index_q;
  assign entry_count_o  = out_count_q;

  `RATI_ASSERT(a_count_max, count_q <= cnt_t'(MAX_ENTRIES), "fill count beyond table size")
  `RATI_ASSERT(a_count_step, count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1, "fill count moved by more than one")
  `RATI_ASSERT_NEVER(a_write_zero_id, mem_req.we && (item_q.ident == '0), "table written for a zero identifier")
  `RATI_ASSERT_NEVER(a_scan_empty, (state_q == S_SCAN) && (count_q == '0), "scan of an empty table")

endmodule

>>> design/rati_mem.sv
`timescale 1ns / 1ps

module rati_mem import rati_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [MAX_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
